// ===== hdl/dtsl_pkg.sv =====
// shared types, register codes and reset values for the dual target slew limiter
package dtsl_pkg;

   localparam int WHEEL_COUNT_DEFAULT = 2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_LIMIT        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICK_PERIOD_MS      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REFERENCE_PERIOD_MS = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLEW_PER_REFERENCE  = 2'd3;

   localparam logic [14:0] TARGET_LIMIT_RESET        = 15'd1000;
   localparam logic [7:0]  TICK_PERIOD_MS_RESET      = 8'd10;
   localparam logic [15:0] REFERENCE_PERIOD_MS_RESET = 16'd100;
   localparam logic [15:0] SLEW_PER_REFERENCE_RESET  = 16'd200;

   localparam int DIVIDEND_W = 33;
   localparam int DIVISOR_W  = 16;

   typedef struct packed {
      logic               mode;
      logic signed [15:0] left_request;
      logic signed [15:0] right_request;
      logic [7:0]         tick_count;
   } req_word_type;

   typedef struct packed {
      logic               accepted;
      logic signed [15:0] left_effective;
      logic signed [15:0] right_effective;
   } rsp_word_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
      logic [DIVISOR_W-1:0]  remainder;
   } div_rsp_type;

endpackage

// ===== hdl/dtsl_divider.sv =====
// radix-2 restoring divider, one quotient bit per cycle
module dtsl_divider
   import dtsl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    shifted;
   logic                  fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial   = shifted - {1'b0, div_req.divisor};
      fits    = shifted >= {1'b0, div_req.divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         quo_in  = div_req.dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ===== hdl/dual_target_slew_limiter.sv =====
// Two-wheel slew limiter: each accepted update word moves the left and right ramps
// toward their requests by a step budget of slew * tick period * ticks / reference
// period, carrying the remainder and capping the step at the target limit. For a stop
// word or a rejected word (zero ticks, request beyond the limit) the word passes the
// check and done states into the output register without a divider pass. A wheel that
// needs a step budget goes through the shared 33-step radix-2 divider, one wheel after
// the other; the divider is the unit that sets the rate. The next word is taken while a
// result waits in the output register. Configuration writes are always ready.
module dual_target_slew_limiter
   import dtsl_pkg::*;
#(
   parameter int WHEEL_COUNT = WHEEL_COUNT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int   WIDX_W     = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;
   localparam int   RIGHT_IDX  = (WHEEL_COUNT > 1) ? 1 : 0;
   localparam logic LAST_WHEEL = (WHEEL_COUNT > 1) ? 1'b1 : 1'b0;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_WHEEL = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic               wheel_ff, wheel_in;
   logic               accepted_ff, accepted_in;
   req_word_type       item_ff, item_in;
   logic [15:0]        elapsed_ff, elapsed_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;
   logic [14:0]        limit_ff, limit_in;
   logic [7:0]         tick_ms_ff, tick_ms_in;
   logic [15:0]        ref_ms_ff, ref_ms_in;
   logic [15:0]        slew_ff, slew_in;

   logic signed [15:0] ramp_ff [WHEEL_COUNT];
   logic signed [15:0] ramp_in [WHEEL_COUNT];
   logic [15:0]        rem_ff  [WHEEL_COUNT];
   logic [15:0]        rem_in  [WHEEL_COUNT];
   logic [15:0]        hold_ff [WHEEL_COUNT];
   logic [15:0]        hold_in [WHEEL_COUNT];

   div_req_type        div_req;
   div_rsp_type        div_rsp;
   logic               div_start;

   logic [WIDX_W-1:0]  widx;
   logic signed [15:0] cur;
   logic signed [15:0] req_sel;
   logic [15:0]        hold_cur;
   logic [15:0]        rem_cur;
   logic [31:0]        slew_prod;
   logic [14:0]        step;
   logic signed [17:0] delta;
   logic signed [17:0] step_s;
   logic signed [17:0] moved;
   logic signed [15:0] ramp_next;
   logic signed [16:0] lim_s;
   logic               in_range;
   logic               wheel_done;

   dtsl_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      widx      = WIDX_W'(wheel_ff);
      cur       = ramp_ff[widx];
      hold_cur  = hold_ff[widx];
      rem_cur   = rem_ff[widx];
      req_sel   = wheel_ff ? item_ff.right_request : item_ff.left_request;
      slew_prod = slew_ff * elapsed_ff;
      lim_s     = $signed({2'b00, limit_ff});
      in_range  = (item_ff.tick_count != 8'd0)
               && (17'(item_ff.left_request) >= -lim_s)
               && (17'(item_ff.left_request) <= lim_s)
               && (17'(item_ff.right_request) >= -lim_s)
               && (17'(item_ff.right_request) <= lim_s);

      if (state_ff == ST_DIV) begin
         step = (div_rsp.quotient > DIVIDEND_W'(limit_ff)) ? limit_ff
                                                           : div_rsp.quotient[14:0];
      end else begin
         step = limit_ff;
      end
      step_s = $signed({3'b000, step});
      delta  = 18'(req_sel) - 18'(cur);
      if (delta > 18'sd0) begin
         moved     = 18'(cur) + step_s;
         ramp_next = (delta <= step_s) ? req_sel : moved[15:0];
      end else begin
         moved     = 18'(cur) - step_s;
         ramp_next = (-delta <= step_s) ? req_sel : moved[15:0];
      end

      div_req.start    = div_start;
      div_req.dividend = {1'b0, slew_prod} + {17'b0, rem_cur};
      div_req.divisor  = ref_ms_ff;
   end

   always_comb begin
      state_in     = state_ff;
      wheel_in     = wheel_ff;
      accepted_in  = accepted_ff;
      item_in      = item_ff;
      elapsed_in   = elapsed_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      limit_in     = limit_ff;
      tick_ms_in   = tick_ms_ff;
      ref_ms_in    = ref_ms_ff;
      slew_in      = slew_ff;
      ramp_in      = ramp_ff;
      rem_in       = rem_ff;
      hold_in      = hold_ff;
      wheel_done   = 1'b0;
      div_start    = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_TARGET_LIMIT:        limit_in   = csr_data[14:0];
            CSR_TICK_PERIOD_MS:      tick_ms_in = csr_data[7:0];
            CSR_REFERENCE_PERIOD_MS: ref_ms_in  = csr_data;
            CSR_SLEW_PER_REFERENCE:  slew_in    = csr_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_word;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (item_ff.mode) begin
               for (int i = 0; i < WHEEL_COUNT; i++) begin
                  ramp_in[i] = '0;
                  rem_in[i]  = '0;
                  hold_in[i] = '0;
               end
               accepted_in = 1'b1;
               state_in    = ST_DONE;
            end else if (in_range) begin
               elapsed_in  = {8'b0, tick_ms_ff} * {8'b0, item_ff.tick_count};
               wheel_in    = 1'b0;
               accepted_in = 1'b1;
               state_in    = ST_WHEEL;
            end else begin
               accepted_in = 1'b0;
               state_in    = ST_DONE;
            end
         end
         ST_WHEEL: begin
            priority if (req_sel == 16'sd0) begin
               ramp_in[widx] = '0;
               rem_in[widx]  = '0;
               hold_in[widx] = '0;
               wheel_done    = 1'b1;
            end else if ((cur > 16'sd0 && req_sel < 16'sd0)
                      || (cur < 16'sd0 && req_sel > 16'sd0)) begin
               ramp_in[widx] = '0;
               rem_in[widx]  = '0;
               hold_in[widx] = (elapsed_ff >= ref_ms_ff) ? 16'd0 : ref_ms_ff - elapsed_ff;
               wheel_done    = 1'b1;
            end else if (hold_cur != 16'd0) begin
               ramp_in[widx] = '0;
               hold_in[widx] = (elapsed_ff >= hold_cur) ? 16'd0 : hold_cur - elapsed_ff;
               wheel_done    = 1'b1;
            end else if (req_sel == cur) begin
               rem_in[widx] = '0;
               wheel_done   = 1'b1;
            end else if (ref_ms_ff == 16'd0) begin
               ramp_in[widx] = ramp_next;
               rem_in[widx]  = '0;
               wheel_done    = 1'b1;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               ramp_in[widx] = ramp_next;
               rem_in[widx]  = div_rsp.remainder;
               wheel_done    = 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_word_in.accepted        = accepted_ff;
               rsp_word_in.left_effective  = ramp_ff[0];
               rsp_word_in.right_effective = (WHEEL_COUNT > 1) ? ramp_ff[RIGHT_IDX] : 16'sd0;
               state_in                    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (wheel_done) begin
         if (wheel_ff == LAST_WHEEL) begin
            state_in = ST_DONE;
         end else begin
            wheel_in = 1'b1;
            state_in = ST_WHEEL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wheel_ff     <= 1'b0;
         accepted_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= TARGET_LIMIT_RESET;
         tick_ms_ff   <= TICK_PERIOD_MS_RESET;
         ref_ms_ff    <= REFERENCE_PERIOD_MS_RESET;
         slew_ff      <= SLEW_PER_REFERENCE_RESET;
         for (int i = 0; i < WHEEL_COUNT; i++) begin
            ramp_ff[i] <= '0;
            rem_ff[i]  <= '0;
            hold_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         wheel_ff     <= wheel_in;
         accepted_ff  <= accepted_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
         tick_ms_ff   <= tick_ms_in;
         ref_ms_ff    <= ref_ms_in;
         slew_ff      <= slew_in;
         ramp_ff      <= ramp_in;
         rem_ff       <= rem_in;
         hold_ff      <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      elapsed_ff  <= elapsed_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign csr_ready = 1'b1;

endmodule

// ===== hdl/dtsl_checker.sv =====
// port-level checks for the dual target slew limiter, bound to the top level
module dtsl_checker
   import dtsl_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // one word in flight: input closes right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again while busy");

   // no result appears in the cycle right after an accept
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result raised too early");

   // ramps never reach the most negative code
   a_ramp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.left_effective != 16'sh8000)
                 && (rsp_word.right_effective != 16'sh8000))
      else $error("ramp value out of range");

endmodule

bind dual_target_slew_limiter dtsl_checker u_dtsl_checker (.*);

// ===== tb/tb_dual_target_slew_limiter.sv =====
// self-checking testbench for the dual target slew limiter with directed, corner, random and backpressure runs
`timescale 1ns / 100ps

module tb_dual_target_slew_limiter;
   import dtsl_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 80;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_word_type           req_word = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_word_type           rsp_word;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_TARGET_LIMIT;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   logic [14:0] lim_cfg  = TARGET_LIMIT_RESET;
   logic [7:0]  tick_cfg = TICK_PERIOD_MS_RESET;
   logic [15:0] ref_cfg  = REFERENCE_PERIOD_MS_RESET;
   logic [15:0] slew_cfg = SLEW_PER_REFERENCE_RESET;

   logic signed [15:0] ramp_now [2] = '{default: '0};
   logic [15:0]        carry_now [2] = '{default: '0};
   logic [15:0]        hold_now [2] = '{default: '0};

   rsp_word_type pending_ramps [$];

   bit reset_done = 1'b0;
   bit steady = 1'b0;
   bit rsp_hold = 1'b0;
   bit offering = 1'b0;
   int fail_count = 0;
   int checked_count = 0;
   int rejected_count = 0;
   int stop_count = 0;
   int settings_count = 0;
   int cycle_count = 0;

   dual_target_slew_limiter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic bit fits_limit(input logic signed [15:0] v);
      return int'(v) >= -int'(lim_cfg) && int'(v) <= int'(lim_cfg);
   endfunction

   function automatic logic signed [15:0] slew_wheel(input int n,
                                                     input logic signed [15:0] target,
                                                     input logic [7:0] ticks);
      logic signed [15:0] cur;
      logic [15:0]        elapsed;
      longint unsigned    budget;
      longint unsigned    quot;
      int                 step;
      int                 delta;
      cur = ramp_now[n];
      elapsed = tick_cfg * ticks;
      if (target == 0) begin
         carry_now[n] = '0;
         hold_now[n] = '0;
         return '0;
      end
      if ((cur > 0 && target < 0) || (cur < 0 && target > 0)) begin
         carry_now[n] = '0;
         hold_now[n] = (elapsed >= ref_cfg) ? 16'd0 : ref_cfg - elapsed;
         return '0;
      end
      if (hold_now[n] != 0) begin
         hold_now[n] = (elapsed >= hold_now[n]) ? 16'd0 : hold_now[n] - elapsed;
         return '0;
      end
      if (target == cur) begin
         carry_now[n] = '0;
         return cur;
      end
      budget = longint'(slew_cfg) * longint'(elapsed) + longint'(carry_now[n]);
      if (ref_cfg == 0) begin
         step = int'(lim_cfg);
         carry_now[n] = '0;
      end else begin
         quot = budget / ref_cfg;
         carry_now[n] = 16'(budget % ref_cfg);
         step = (quot > lim_cfg) ? int'(lim_cfg) : int'(quot);
      end
      delta = int'(target) - int'(cur);
      if (delta > 0)
         return (delta <= step) ? target : 16'(int'(cur) + step);
      return (-delta <= step) ? target : 16'(int'(cur) - step);
   endfunction

   function automatic rsp_word_type advance_ramps(input req_word_type w);
      rsp_word_type r;
      r.accepted = 1'b0;
      if (w.mode) begin
         ramp_now = '{default: '0};
         carry_now = '{default: '0};
         hold_now = '{default: '0};
         r.accepted = 1'b1;
      end else if (w.tick_count != 0 && fits_limit(w.left_request) &&
                   fits_limit(w.right_request)) begin
         ramp_now[0] = slew_wheel(0, w.left_request, w.tick_count);
         ramp_now[1] = slew_wheel(1, w.right_request, w.tick_count);
         r.accepted = 1'b1;
      end
      r.left_effective = ramp_now[0];
      r.right_effective = ramp_now[1];
      return r;
   endfunction

   function automatic logic signed [15:0] pick_goal();
      int lim;
      lim = int'(lim_cfg);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 16'(lim);
         2: return 16'(-lim);
         default: return 16'(int'($urandom_range(0, 2 * lim)) - lim);
      endcase
   endfunction

   task automatic send_word(input logic m, input logic signed [15:0] l, r,
                            input logic [7:0] t);
      req_word_type w;
      int gap;
      w.mode = m;
      w.left_request = l;
      w.right_request = r;
      w.tick_count = t;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap != 0 && offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
      repeat (gap) @(posedge clock);
      req_valid <= 1'b1;
      req_word <= w;
      offering = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_ramps.push_back(advance_ramps(w));
   endtask

   task automatic drain_words();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
      while (pending_ramps.size() != 0) @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] lim, tick, refp, slew);
      logic [CSR_DATA_W-1:0]  vals [4];
      logic [CSR_INDEX_W-1:0] idx [4];
      drain_words();
      vals[0] = {1'($urandom), lim[14:0]};
      vals[1] = {8'($urandom), tick[7:0]};
      vals[2] = refp;
      vals[3] = slew;
      idx[0] = CSR_TARGET_LIMIT;
      idx[1] = CSR_TICK_PERIOD_MS;
      idx[2] = CSR_REFERENCE_PERIOD_MS;
      idx[3] = CSR_SLEW_PER_REFERENCE;
      for (int k = 0; k < 4; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data <= vals[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      lim_cfg = lim[14:0];
      tick_cfg = tick[7:0];
      ref_cfg = refp;
      slew_cfg = slew;
      settings_count++;
   endtask

   task automatic random_burst(input int count);
      logic signed [15:0] goal [2];
      logic [7:0]         ticks;
      int                 roll;
      goal[0] = pick_goal();
      goal[1] = pick_goal();
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            send_word(1'b1, 16'($urandom), 16'($urandom), 8'($urandom));
         end else if (roll < 7) begin
            send_word(1'b0, goal[0], goal[1], 8'd0);
         end else if (roll < 12) begin
            send_word(1'b0, 16'($urandom), 16'($urandom), 8'($urandom));
         end else begin
            for (int n = 0; n < 2; n++)
               if ($urandom_range(0, 4) == 0)
                  goal[n] = pick_goal();
            ticks = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255))
                                                : 8'($urandom_range(1, 8));
            send_word(1'b0, goal[0], goal[1], ticks);
         end
      end
   endtask

   task automatic test_reset_defaults();
      send_word(1'b0, 16'sd1000, -16'sd1000, 8'd255);
      send_word(1'b0, -16'sd1000, 16'sd1000, 8'd1);
      send_word(1'b0, -16'sd500, 16'sd500, 8'd5);
      send_word(1'b0, -16'sd500, 16'sd500, 8'd4);
      send_word(1'b0, -16'sd500, 16'sd500, 8'd3);
      send_word(1'b0, -16'sd60, 16'sd60, 8'd1);
      send_word(1'b0, 16'sd0, 16'sd0, 8'd1);
      send_word(1'b0, 16'sd5, 16'sd5, 8'd0);
      send_word(1'b0, 16'sd1001, 16'sd0, 8'd1);
      send_word(1'b0, 16'sd0, -16'sd1001, 8'd1);
      send_word(1'b0, 16'sd32767, -16'sd32768, 8'd255);
      send_word(1'b0, 16'sd7, -16'sd7, 8'd1);
      send_word(1'b1, -16'sd1, 16'sd32767, 8'd255);
      drain_words();
   endtask

   task automatic test_corner_settings();
      set_config(16'd0, 16'd10, 16'd100, 16'd200);
      send_word(1'b0, 16'sd0, 16'sd0, 8'd3);
      send_word(1'b0, 16'sd1, 16'sd0, 8'd3);
      send_word(1'b0, 16'sd0, -16'sd1, 8'd3);
      set_config(16'd300, 16'd7, 16'd0, 16'd5);
      send_word(1'b0, 16'sd300, -16'sd300, 8'd1);
      send_word(1'b0, -16'sd100, 16'sd100, 8'd2);
      send_word(1'b0, -16'sd100, 16'sd100, 8'd1);
      set_config(16'd500, 16'd3, 16'd7, 16'd5);
      send_word(1'b0, 16'sd100, -16'sd100, 8'd1);
      send_word(1'b0, 16'sd100, -16'sd100, 8'd2);
      set_config(16'd500, 16'd0, 16'd7, 16'd5);
      send_word(1'b0, 16'sd100, -16'sd100, 8'd1);
      send_word(1'b0, -16'sd100, 16'sd100, 8'd9);
      send_word(1'b0, -16'sd100, 16'sd100, 8'd9);
      send_word(1'b0, 16'sd0, 16'sd0, 8'd1);
      drain_words();
   endtask

   task automatic test_random_updates();
      set_config(16'd32767, 16'd255, 16'd65535, 16'd65535);
      random_burst(100);
      set_config(16'd1, 16'd1, 16'd1, 16'd0);
      random_burst(100);
      set_config(16'(TARGET_LIMIT_RESET), 16'(TICK_PERIOD_MS_RESET),
                 REFERENCE_PERIOD_MS_RESET, SLEW_PER_REFERENCE_RESET);
      steady = 1'b1;
      random_burst(100);
      steady = 1'b0;
      for (int p = 0; p < 8; p++) begin
         set_config(16'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 32767)
                                                    : $urandom_range(1, 3000)),
                    16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(1, 20)),
                    16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(1, 1000)),
                    16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 3000)));
         random_burst(100);
      end
      drain_words();
   endtask

   task automatic test_stall_pressure();
      set_config(16'd2000, 16'd5, 16'd37, 16'd90);
      fork
         begin
            rsp_hold = 1'b1;
            repeat (400) @(posedge clock);
            rsp_hold = 1'b0;
         end
         random_burst(200);
      join
      drain_words();
   endtask

   initial begin : rsp_side
      int           gap;
      rsp_word_type want;
      wait (reset_done);
      forever begin
         gap = steady ? 0 : $urandom_range(0, 4);
         while (gap > 0 || rsp_hold) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
            if (gap > 0)
               gap--;
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (pending_ramps.size() == 0) begin
            $error("result word with no update pending");
            fail_count++;
         end else begin
            want = pending_ramps.pop_front();
            checked_count++;
            if (!want.accepted)
               rejected_count++;
            if (rsp_word.accepted !== want.accepted) begin
               $error("accepted: expected %0d, got %0d", want.accepted, rsp_word.accepted);
               fail_count++;
            end
            if (rsp_word.left_effective !== want.left_effective) begin
               $error("left_effective: expected %0d, got %0d", want.left_effective,
                      rsp_word.left_effective);
               fail_count++;
            end
            if (rsp_word.right_effective !== want.right_effective) begin
               $error("right_effective: expected %0d, got %0d", want.right_effective,
                      rsp_word.right_effective);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock)
      if (req_valid && !req_stall && req_word.mode)
         stop_count++;

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      reset_done = 1'b1;
      @(posedge clock);
      test_reset_defaults();
      test_corner_settings();
      test_random_updates();
      test_stall_pressure();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d result words checked under %0d register settings", checked_count,
               settings_count);
      $display("%0d updates rejected, %0d stop words, one long output hold", rejected_count,
               stop_count);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
